// File: hw/rtl/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_CHANNELS = 2;

    localparam int POS_BITS  = FRAC_BITS + 3;
    localparam int STEP_BITS = FRAC_BITS + 3;
    localparam int CCNT_BITS = 2;
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + FRAC_BITS + 1;

    localparam logic [POS_BITS-1:0]  ONE_POS  = POS_BITS'(1) << FRAC_BITS;
    localparam logic [POS_BITS-1:0]  TWO_POS  = POS_BITS'(1) << (FRAC_BITS + 1);
    localparam logic [STEP_BITS-1:0] STEP_MIN = STEP_BITS'(1) << (FRAC_BITS - 2);
    localparam logic [STEP_BITS-1:0] STEP_MAX = STEP_BITS'(1) << (FRAC_BITS + 2);

    localparam logic [STEP_BITS-1:0] PHASE_STEP_RST    = STEP_BITS'(1) << FRAC_BITS;
    localparam logic [CCNT_BITS-1:0] CHANNEL_COUNT_RST = CCNT_BITS'(1);

    localparam logic REG_PHASE_STEP    = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        KIND_INTERP = 2'd0,
        KIND_HOLD   = 2'd1,
        KIND_MARKER = 2'd2
    } emit_kind_t;

    typedef struct packed {
        logic       load_in;
        logic       emit;
        emit_kind_t kind;
        logic       last;
        logic       stream_end;
        logic       advance;
        logic       wrap;
        logic       clear;
    } lir_cmd_t;

    typedef struct packed {
        logic pos_lt_one;
        logic next_ge_one;
        logic next_ge_two;
        logic out_free;
        logic have_prev;
        logic in_final;
        logic cur_final;
    } lir_status_t;

endpackage

// File: hw/rtl/lir_ctrl.sv
`timescale 1ns / 1ps

module lir_ctrl
    import lir_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  lir_status_t status,
    output lir_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INTERP = 2'd1;
    localparam logic [1:0] ST_HOLD   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       emitted_reg;
    logic       emitted_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            emitted_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            emitted_reg <= emitted_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        emitted_next   = emitted_reg;
        cmd            = '0;
        cmd.kind       = KIND_INTERP;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load_in  = 1'b1;
                    emitted_next = 1'b0;
                    if (status.have_prev) begin
                        state_next = ST_INTERP;
                    end else if (status.in_final) begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_INTERP: begin
                if (status.pos_lt_one) begin
                    if (status.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.kind       = KIND_INTERP;
                        cmd.advance    = 1'b1;
                        cmd.last       = status.cur_final ? status.next_ge_two
                                                          : status.next_ge_one;
                        cmd.stream_end = status.cur_final & status.next_ge_two;
                        emitted_next   = 1'b1;
                    end
                end else begin
                    cmd.wrap   = 1'b1;
                    state_next = status.cur_final ? ST_HOLD : ST_IDLE;
                end
            end
            ST_HOLD: begin
                if (status.pos_lt_one) begin
                    if (status.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.kind       = KIND_HOLD;
                        cmd.advance    = 1'b1;
                        cmd.last       = status.next_ge_one;
                        cmd.stream_end = status.next_ge_one;
                        emitted_next   = 1'b1;
                    end
                end else if (emitted_reg) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.kind       = KIND_MARKER;
                    cmd.last       = 1'b1;
                    cmd.stream_end = 1'b1;
                    cmd.clear      = 1'b1;
                    emitted_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/lir_dp.sv
`timescale 1ns / 1ps

module lir_dp
    import lir_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [STEP_BITS-1:0]          phase_step,
    input  logic [CCNT_BITS-1:0]          channel_count,
    input  logic signed [SAMPLE_BITS-1:0] in_left,
    input  logic signed [SAMPLE_BITS-1:0] in_right,
    input  logic                          in_final,
    input  lir_cmd_t                      cmd,
    output lir_status_t                   status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    output logic                          out_sample_valid,
    output logic                          out_last,
    output logic                          out_stream_end
);

    logic signed [SAMPLE_BITS-1:0] prev_left_reg;
    logic signed [SAMPLE_BITS-1:0] prev_right_reg;
    logic signed [SAMPLE_BITS-1:0] cur_left_reg;
    logic signed [SAMPLE_BITS-1:0] cur_right_reg;
    logic                          cur_final_reg;
    logic                          have_prev_reg;
    logic [POS_BITS-1:0]           pos_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;
    logic                          out_sv_reg;
    logic                          out_last_reg;
    logic                          out_end_reg;

    logic [STEP_BITS-1:0]          step_sat;
    logic [POS_BITS-1:0]           pos_sum;
    logic                          stereo;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [DIFF_BITS-1:0]   diff_l;
    logic signed [DIFF_BITS-1:0]   diff_r;
    logic signed [PROD_BITS-1:0]   prod_l;
    logic signed [PROD_BITS-1:0]   prod_r;
    logic signed [PROD_BITS-1:0]   rnd_l;
    logic signed [PROD_BITS-1:0]   rnd_r;
    logic signed [SAMPLE_BITS-1:0] lerp_l;
    logic signed [SAMPLE_BITS-1:0] lerp_r;
    logic signed [SAMPLE_BITS-1:0] res_l;
    logic signed [SAMPLE_BITS-1:0] res_r;

    always_comb begin
        priority if (phase_step < STEP_MIN) begin
            step_sat = STEP_MIN;
        end else if (phase_step > STEP_MAX) begin
            step_sat = STEP_MAX;
        end else begin
            step_sat = phase_step;
        end
    end

    assign stereo  = (MAX_CHANNELS >= 2) && channel_count[1];
    assign pos_sum = pos_reg + POS_BITS'(step_sat);

    assign frac_s = $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
    assign diff_l = DIFF_BITS'(cur_left_reg) - DIFF_BITS'(prev_left_reg);
    assign diff_r = DIFF_BITS'(cur_right_reg) - DIFF_BITS'(prev_right_reg);
    assign prod_l = PROD_BITS'(frac_s) * PROD_BITS'(diff_l);
    assign prod_r = PROD_BITS'(frac_s) * PROD_BITS'(diff_r);
    assign rnd_l  = (prod_l + (PROD_BITS'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign rnd_r  = (prod_r + (PROD_BITS'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign lerp_l = prev_left_reg + rnd_l[SAMPLE_BITS-1:0];
    assign lerp_r = prev_right_reg + rnd_r[SAMPLE_BITS-1:0];

    always_comb begin
        unique case (cmd.kind)
            KIND_INTERP: begin
                res_l = lerp_l;
                res_r = stereo ? lerp_r : '0;
            end
            KIND_HOLD: begin
                res_l = cur_left_reg;
                res_r = stereo ? cur_right_reg : '0;
            end
            default: begin
                res_l = '0;
                res_r = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            have_prev_reg  <= 1'b0;
            pos_reg        <= '0;
            cur_final_reg  <= 1'b0;
        end else begin
            if (cmd.clear) begin
                prev_left_reg  <= '0;
                prev_right_reg <= '0;
                have_prev_reg  <= 1'b0;
                pos_reg        <= '0;
            end else if (cmd.load_in) begin
                cur_final_reg <= in_final;
                if (!have_prev_reg) begin
                    prev_left_reg  <= in_left;
                    prev_right_reg <= in_right;
                    have_prev_reg  <= 1'b1;
                end
            end else if (cmd.advance) begin
                pos_reg <= pos_sum;
            end else if (cmd.wrap) begin
                pos_reg        <= pos_reg - ONE_POS;
                prev_left_reg  <= cur_left_reg;
                prev_right_reg <= cur_right_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cur_left_reg  <= in_left;
            cur_right_reg <= in_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_left_reg  <= res_l;
            out_right_reg <= res_r;
            out_sv_reg    <= (cmd.kind != KIND_MARKER);
            out_last_reg  <= cmd.last;
            out_end_reg   <= cmd.stream_end;
        end
    end

    assign status.pos_lt_one  = (pos_reg < ONE_POS);
    assign status.next_ge_one = (pos_sum >= ONE_POS);
    assign status.next_ge_two = (pos_sum >= TWO_POS);
    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.have_prev   = have_prev_reg;
    assign status.in_final    = in_final;
    assign status.cur_final   = cur_final_reg;

    assign out_valid        = out_valid_reg;
    assign out_left         = out_left_reg;
    assign out_right        = out_right_reg;
    assign out_sample_valid = out_sv_reg;
    assign out_last         = out_last_reg;
    assign out_stream_end   = out_end_reg;

endmodule

// File: hw/rtl/linear_interp_resampler.sv
`timescale 1ns / 1ps

// Linear interpolation resampler for mono or stereo 16-bit frames. An ordinary
// frame yields n output samples, where n is 0 to 4, and goes through the input
// transfer, the n output samples from the shared interpolator, and a step that
// moves the phase on to the next frame. The first frame of a stream is only
// stored and needs just its transfer, unless it is also final. The final frame
// adds the held samples and a closing step, which also carries the end marker
// when no sample came out. Output samples leave through a one-deep output
// register; a stalled output holds the interpolator.

module linear_interp_resampler
    import lir_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_sample, right_sample
    input  logic        s_tlast,   // final_frame

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_out, right_out
    output logic [1:0]  m_tuser,   // sample_valid, stream_end
    output logic        m_tlast,   // last_of_run

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [STEP_BITS-1:0]          phase_step_reg;
    logic [CCNT_BITS-1:0]          channel_count_reg;
    logic                          cfg_write;

    lir_cmd_t                      cmd;
    lir_status_t                   status;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          out_sample_valid;
    logic                          out_stream_end;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg    <= PHASE_STEP_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_PHASE_STEP:    phase_step_reg    <= pwdata[STEP_BITS-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[CCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PHASE_STEP:    prdata = 32'(phase_step_reg);
            REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
            default:           prdata = '0;
        endcase
    end

    lir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lir_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .phase_step       (phase_step_reg),
        .channel_count    (channel_count_reg),
        .in_left          (s_tdata[SAMPLE_BITS-1:0]),
        .in_right         (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .in_final         (s_tlast),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_left         (out_left),
        .out_right        (out_right),
        .out_sample_valid (out_sample_valid),
        .out_last         (m_tlast),
        .out_stream_end   (out_stream_end)
    );

    assign m_tdata = {out_right, out_left};
    assign m_tuser = {out_stream_end, out_sample_valid};

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lir_pkg::*;

    localparam int RANDOM_FRAMES  = 400;
    localparam int HOLD_AT        = 200;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        sample_valid;
        logic        last_of_run;
        logic        stream_end;
    } out_frame_t;

    class resample_scoreboard;
        logic [STEP_BITS-1:0] step_reg;
        logic [CCNT_BITS-1:0] chan_reg;
        logic signed [15:0]   prev_l;
        logic signed [15:0]   prev_r;
        bit                   have_prev;
        int unsigned          pos;
        out_frame_t           expected_q[$];
        int                   errors;

        function new();
            step_reg  = PHASE_STEP_RST;
            chan_reg  = CHANNEL_COUNT_RST;
            prev_l    = '0;
            prev_r    = '0;
            have_prev = 0;
            pos       = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_PHASE_STEP)
                step_reg = value[STEP_BITS-1:0];
            else
                chan_reg = value[CCNT_BITS-1:0];
        endfunction

        function logic [15:0] lerp(logic signed [15:0] s0, logic signed [15:0] s1,
                                   int unsigned t);
            longint p;
            p = longint'(t) * (longint'(s1) - longint'(s0)) + 64'sd32768;
            return 16'(longint'(s0) + (p >>> FRAC_BITS));
        endfunction

        function void push_sample(logic [15:0] l, logic [15:0] r, logic valid);
            out_frame_t item;
            item.left         = l;
            item.right        = r;
            item.sample_valid = valid;
            item.last_of_run  = 1'b0;
            item.stream_end   = 1'b0;
            expected_q.push_back(item);
        endfunction

        function void note_frame(logic signed [15:0] nl, logic signed [15:0] nr,
                                 logic fin);
            int unsigned step;
            bit          stereo;
            int          first;
            out_frame_t  tail;
            step = step_reg;
            if (step < STEP_MIN) step = STEP_MIN;
            if (step > STEP_MAX) step = STEP_MAX;
            stereo = (chan_reg >= 2) && (MAX_CHANNELS >= 2);
            first  = expected_q.size();
            if (have_prev) begin
                while (pos < ONE_POS) begin
                    push_sample(lerp(prev_l, nl, pos),
                                stereo ? lerp(prev_r, nr, pos) : 16'h0000, 1'b1);
                    pos += step;
                end
                pos -= ONE_POS;
            end
            prev_l    = nl;
            prev_r    = nr;
            have_prev = 1;
            if (fin) begin
                while (pos < ONE_POS) begin
                    push_sample(nl, stereo ? nr : 16'h0000, 1'b1);
                    pos += step;
                end
                if (expected_q.size() == first)
                    push_sample(16'h0000, 16'h0000, 1'b0);
                tail = expected_q.pop_back();
                tail.stream_end = 1'b1;
                expected_q.push_back(tail);
                prev_l    = '0;
                prev_r    = '0;
                have_prev = 0;
                pos       = 0;
            end
            if (expected_q.size() > first) begin
                tail = expected_q.pop_back();
                tail.last_of_run = 1'b1;
                expected_q.push_back(tail);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_frame_t got);
            out_frame_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("left_out", want.left, got.left);
            compare_field("right_out", want.right, got.right);
            compare_field("sample_valid", 16'(want.sample_valid), 16'(got.sample_valid));
            compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
            compare_field("stream_end", 16'(want.stream_end), 16'(got.stream_end));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    resample_scoreboard sb = new();
    out_frame_t         seen;
    int                 frames_in    = 0;
    int                 idle_cycles  = 0;
    int                 hold_phase   = 0;
    bit                 source_eager = 0;
    bit                 sink_eager   = 0;

    linear_interp_resampler dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_frame(s_tdata[15:0], s_tdata[31:16], s_tlast);
            frames_in++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.left         = m_tdata[15:0];
            seen.right        = m_tdata[31:16];
            seen.sample_valid = m_tuser[0];
            seen.stream_end   = m_tuser[1];
            seen.last_of_run  = m_tlast;
            sb.check_result(seen);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result sink: random stalls, bursts without stalls, one long hold-off
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_phase == 0 && frames_in >= HOLD_AT) begin
                hold_phase = 1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_phase = 2;
            end
            stall = sink_eager ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
            if ($urandom_range(0, 31) == 0) sink_eager = !sink_eager;
        end
    end

    task automatic send_frame(input logic [15:0] left, input logic [15:0] right,
                              input logic fin);
        int gap;
        gap = source_eager ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if ($urandom_range(0, 31) == 0) source_eager = !source_eager;
    endtask

    task automatic apb_access(input logic idx, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr) sb.write_reg(idx, wdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_reg(input logic idx, input logic [31:0] want);
        logic [31:0] data;
        apb_access(idx, 1'b0, 32'h0, data);
        if (data !== want) begin
            $display("%0t: register %0d readback, expected %h, got %h",
                     $time, idx, want, data);
            sb.errors++;
        end
    endtask

    // hold input until every expected transfer is out and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [31:0] step, input logic [31:0] chans);
        logic [31:0] unused;
        settle();
        apb_access(REG_PHASE_STEP, 1'b1, step, unused);
        apb_access(REG_CHANNEL_COUNT, 1'b1, chans, unused);
        check_reg(REG_PHASE_STEP, 32'(step[STEP_BITS-1:0]));
        check_reg(REG_CHANNEL_COUNT, 32'(chans[CCNT_BITS-1:0]));
    endtask

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] draw_step();
        logic [31:0] noise;
        noise = $urandom;
        case ($urandom_range(0, 9))
            0:       return {noise[31:STEP_BITS], STEP_MIN};
            1:       return {noise[31:STEP_BITS], STEP_MAX};
            2:       return 32'(PHASE_STEP_RST);
            3:       return 32'($urandom_range(0, STEP_MIN - 1));
            4:       return 32'($urandom_range(STEP_MAX + 1, (1 << STEP_BITS) - 1));
            default: return 32'($urandom_range(STEP_MIN, STEP_MAX));
        endcase
    endfunction

    initial begin : stimulus
        int frames_sent;
        int stream_left;
        int frames_since_cfg;
        int phase_len;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        aresetn  = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        check_reg(REG_PHASE_STEP, 32'(PHASE_STEP_RST));
        check_reg(REG_CHANNEL_COUNT, 32'(CHANNEL_COUNT_RST));
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h7FFF, 16'h0001, 1'b0);
        send_frame(16'h0000, 16'hFFFF, 1'b1);

        set_config(32'(STEP_MIN), 32'd2);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h5555, 16'hAAAA, 1'b1);

        // final frame past the last position gives the bare end marker
        set_config(32'(STEP_MAX), 32'd3);
        send_frame(16'h1234, 16'hFEDC, 1'b0);
        send_frame(16'hFFFF, 16'h0001, 1'b0);
        send_frame(16'h4000, 16'hC000, 1'b1);
        send_frame(16'h0F0F, 16'hF0F0, 1'b1);

        set_config(32'h0000_0000, 32'd0);
        send_frame(16'h00FF, 16'hFF00, 1'b0);
        send_frame(16'hFF00, 16'h00FF, 1'b1);

        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(16'hAAAA, 16'h5555, 1'b0);
        send_frame(16'h8001, 16'h7FFE, 1'b0);
        send_frame(16'h0001, 16'hFFFE, 1'b1);

        frames_sent      = 0;
        stream_left      = 0;
        frames_since_cfg = 0;
        phase_len        = 0;
        while (frames_sent < RANDOM_FRAMES) begin
            if (frames_since_cfg >= phase_len && hold_phase != 1 &&
                !(hold_phase == 0 && frames_in >= HOLD_AT - 30)) begin
                set_config(draw_step(), $urandom);
                frames_since_cfg = 0;
                phase_len = $urandom_range(30, 80);
            end
            if (stream_left == 0)
                stream_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
            send_frame(draw_sample(), draw_sample(), stream_left == 1);
            stream_left--;
            frames_sent++;
            frames_since_cfg++;
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: linear_interp_resampler.f
hw/rtl/lir_pkg.sv
hw/rtl/lir_ctrl.sv
hw/rtl/lir_dp.sv
hw/rtl/linear_interp_resampler.sv
bench/tb_top.sv
